// ----- hw/rtl/wla_pkg.sv -----
// ----------------------------------------------------------------------------
// wla_pkg
// Shared types and codes for the weight limit alarm block.
// ----------------------------------------------------------------------------
package wla_pkg;

    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned ADDR_W   = 4;

    localparam logic [COUNT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LONG = 2'd1,
        OP_EXIT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DEV_OK   = 2'd0,
        DEV_LOW  = 2'd1,
        DEV_HIGH = 2'd2
    } dev_t;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_INTERVAL   = 2'd0,
        REG_ERROR_LIM  = 2'd1,
        REG_LOW_LIMIT  = 2'd2,
        REG_HIGH_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         sample_interval;
        logic [COUNT_W-1:0]         error_limit;
        logic signed [WEIGHT_W-1:0] low_limit;
        logic signed [WEIGHT_W-1:0] high_limit;
    } cfg_t;

    typedef struct packed {
        logic                       alarm;
        logic                       armed;
        logic [COUNT_W-1:0]         error_count;
        logic [1:0]                 deviation;
        logic [COUNT_W-1:0]         ticks_left;
        logic signed [WEIGHT_W-1:0] last_weight;
    } result_t;

endpackage

// ----- hw/rtl/wla_cfg.sv -----
// ----------------------------------------------------------------------------
// wla_cfg
// APB register file: sample interval, error limit, low and high limits.
// ----------------------------------------------------------------------------
module wla_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wla_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output wla_pkg::cfg_t               cfg
);

    wla_pkg::cfg_t      cfg_reg;
    wla_pkg::cfg_t      cfg_next;
    wla_pkg::reg_idx_t  idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = wla_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                wla_pkg::REG_INTERVAL:   cfg_next.sample_interval = pwdata[7:0];
                wla_pkg::REG_ERROR_LIM:  cfg_next.error_limit     = pwdata[7:0];
                wla_pkg::REG_LOW_LIMIT:  cfg_next.low_limit       = signed'(pwdata);
                wla_pkg::REG_HIGH_LIMIT: cfg_next.high_limit      = signed'(pwdata);
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            wla_pkg::REG_INTERVAL:   prdata = {24'd0, cfg_reg.sample_interval};
            wla_pkg::REG_ERROR_LIM:  prdata = {24'd0, cfg_reg.error_limit};
            wla_pkg::REG_LOW_LIMIT:  prdata = unsigned'(cfg_reg.low_limit);
            wla_pkg::REG_HIGH_LIMIT: prdata = unsigned'(cfg_reg.high_limit);
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= 8'd1;
            cfg_reg.error_limit     <= 8'd3;
            cfg_reg.low_limit       <= '0;
            cfg_reg.high_limit      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/wla_core.sv -----
// ----------------------------------------------------------------------------
// wla_core
// Checker state and its per-word update.
// ----------------------------------------------------------------------------
module wla_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step_en,
    input  logic [1:0]                         operation,
    input  logic signed [wla_pkg::WEIGHT_W-1:0] weight_sample,
    input  wla_pkg::cfg_t                      cfg,
    output wla_pkg::result_t                   result
);

    logic [wla_pkg::COUNT_W-1:0]         tick_reg,  tick_next;
    logic signed [wla_pkg::WEIGHT_W-1:0] held_reg,  held_next;
    logic [wla_pkg::COUNT_W-1:0]         fault_reg, fault_next;
    logic [1:0]                          dev_reg,   dev_next;
    logic                                alarm_reg, alarm_next;
    logic                                arm_reg,   arm_next;
    logic [wla_pkg::COUNT_W-1:0]         tick_inc;
    logic                                low_hit;
    logic                                high_hit;
    wla_pkg::op_t                        op;

    assign op       = wla_pkg::op_t'(operation);
    assign tick_inc = tick_reg + 8'd1;
    assign low_hit  = (cfg.low_limit != '0) && (weight_sample < cfg.low_limit);
    assign high_hit = (cfg.high_limit != '0) && (weight_sample > cfg.high_limit);

    always_comb
    begin
        tick_next  = tick_reg;
        held_next  = held_reg;
        fault_next = fault_reg;
        dev_next   = dev_reg;
        alarm_next = alarm_reg;
        arm_next   = arm_reg;

        unique case (op)
            wla_pkg::OP_TICK:
            begin
                // ticks during a latched alarm are dropped
                if (!alarm_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.sample_interval)
                    begin
                        tick_next = '0;
                        held_next = weight_sample;
                        if (arm_reg)
                        begin
                            if (low_hit)
                                dev_next = wla_pkg::DEV_LOW;
                            else if (high_hit)
                                dev_next = wla_pkg::DEV_HIGH;
                            else
                                dev_next = wla_pkg::DEV_OK;
                            if (low_hit || high_hit)
                            begin
                                if (fault_reg != wla_pkg::FAULT_MAX)
                                    fault_next = fault_reg + 8'd1;
                            end
                            else
                            begin
                                fault_next = '0;
                            end
                        end
                    end
                end
            end
            wla_pkg::OP_LONG:
            begin
                if (alarm_reg)
                begin
                    arm_next   = 1'b0;
                    dev_next   = wla_pkg::DEV_OK;
                    fault_next = '0;
                    alarm_next = 1'b0;
                end
                else
                begin
                    arm_next = !arm_reg;
                end
            end
            wla_pkg::OP_EXIT:
            begin
                arm_next   = 1'b0;
                dev_next   = wla_pkg::DEV_OK;
                fault_next = '0;
                alarm_next = 1'b0;
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase

        // latch check runs after every word, even with checking off
        if (!alarm_next && (fault_next >= cfg.error_limit))
            alarm_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            held_reg  <= '0;
            fault_reg <= '0;
            dev_reg   <= wla_pkg::DEV_OK;
            alarm_reg <= 1'b0;
            arm_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            tick_reg  <= tick_next;
            held_reg  <= held_next;
            fault_reg <= fault_next;
            dev_reg   <= dev_next;
            alarm_reg <= alarm_next;
            arm_reg   <= arm_next;
        end
    end

    always_comb
    begin
        result.alarm       = alarm_next;
        result.armed       = arm_next;
        result.error_count = fault_next;
        result.deviation   = dev_next;
        result.ticks_left  = (cfg.sample_interval > tick_next)
                             ? (cfg.sample_interval - tick_next) : '0;
        result.last_weight = held_next;
    end

endmodule

// ----- hw/rtl/weight_limit_alarm_top.sv -----
// ----------------------------------------------------------------------------
// weight_limit_alarm_top
// Each word passes the input register, then the result register; one word
// per cycle sustained while out_stall is low.
// Reset: asynchronous, active low; config, checker and valid registers
// return to their reset values, emptying both pipeline stages (their data registers are not reset).
// ----------------------------------------------------------------------------
module weight_limit_alarm_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic signed [wla_pkg::WEIGHT_W-1:0] weight_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                alarm,
    output logic                                armed,
    output logic [wla_pkg::COUNT_W-1:0]         error_count,
    output logic [1:0]                          deviation,
    output logic [wla_pkg::COUNT_W-1:0]         ticks_left,
    output logic signed [wla_pkg::WEIGHT_W-1:0] last_weight,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wla_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    wla_pkg::cfg_t                       cfg;
    wla_pkg::result_t                    result;
    wla_pkg::result_t                    res_reg;
    logic                                in_vld_reg;
    logic [1:0]                          op_reg;
    logic signed [wla_pkg::WEIGHT_W-1:0] weight_reg;
    logic                                out_vld_reg;
    logic                                step_en;
    logic                                in_take;

    // the input stage moves on when the result register is free or drains
    assign step_en  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !step_en;
    assign in_take  = in_valid && !in_stall;

    wla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wla_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .operation     (op_reg),
        .weight_sample (weight_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (step_en)
                in_vld_reg <= 1'b0;

            if (step_en)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= operation;
            weight_reg <= weight_sample;
        end
        if (step_en)
            res_reg <= result;
    end

    assign out_valid   = out_vld_reg;
    assign alarm       = res_reg.alarm;
    assign armed       = res_reg.armed;
    assign error_count = res_reg.error_count;
    assign deviation   = res_reg.deviation;
    assign ticks_left  = res_reg.ticks_left;
    assign last_weight = res_reg.last_weight;

endmodule
